@@ rtl/core/tpa_pkg.sv @@
`default_nettype none
package tpa_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int REQ_TDATA_WIDTH = 72;
   localparam int RSP_TDATA_WIDTH = 192;

   localparam logic ACT_BEGIN  = 1'b0;
   localparam logic ACT_VERTEX = 1'b1;

   typedef enum logic [1:0] {
      MODE_LIST    = 2'd0,
      MODE_FAN     = 2'd1,
      MODE_STRIP   = 2'd2,
      MODE_IGNORED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_EMIT_A = 2'd2,
      PHASE_EMIT_B = 2'd3
   } phase_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] ax;
      logic [FIELD_WIDTH-1:0] ay;
      logic [FIELD_WIDTH-1:0] bx;
      logic [FIELD_WIDTH-1:0] by;
      logic [FIELD_WIDTH-1:0] cx;
      logic [FIELD_WIDTH-1:0] cy;
   } tri_type;

endpackage
`default_nettype wire

@@ rtl/core/tpa_assemble.sv @@
`default_nettype none
module tpa_assemble
   import tpa_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   action,
   input  wire logic [1:0]             prim_type,
   input  wire logic [FIELD_WIDTH-1:0] vert_x,
   input  wire logic [FIELD_WIDTH-1:0] vert_y,
   output logic                        emit_valid,
   output tri_type                     tri_out
);

   // stored corners keep only the bits that survive both the coordinate and the port width
   localparam int SLOT_WIDTH = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

   mode_type              mode_ff, mode_in;
   phase_type             phase_ff, phase_in;
   logic [SLOT_WIDTH-1:0] a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic [SLOT_WIDTH-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic [SLOT_WIDTH-1:0] cur_x, cur_y;
   logic                  vertex_live;

   assign cur_x = vert_x[SLOT_WIDTH-1:0];
   assign cur_y = vert_y[SLOT_WIDTH-1:0];
   assign vertex_live = accept && (action == ACT_VERTEX) && (mode_ff != MODE_IGNORED);

   // next state
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      a_x_in   = a_x_ff;
      a_y_in   = a_y_ff;
      b_x_in   = b_x_ff;
      b_y_in   = b_y_ff;
      if (accept && (action == ACT_BEGIN)) begin
         mode_in  = mode_type'(prim_type);
         phase_in = PHASE_FIRST;
      end else if (vertex_live) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               a_x_in   = cur_x;
               a_y_in   = cur_y;
               phase_in = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               b_x_in   = cur_x;
               b_y_in   = cur_y;
               phase_in = PHASE_EMIT_A;
            end
            default: begin
               priority if (mode_ff == MODE_LIST) begin
                  phase_in = PHASE_FIRST;
               end else if (mode_ff == MODE_FAN) begin
                  b_x_in = cur_x;
                  b_y_in = cur_y;
               end else if (phase_ff == PHASE_EMIT_A) begin
                  a_x_in   = cur_x;
                  a_y_in   = cur_y;
                  phase_in = PHASE_EMIT_B;
               end else begin
                  b_x_in   = cur_x;
                  b_y_in   = cur_y;
                  phase_in = PHASE_EMIT_A;
               end
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      emit_valid = vertex_live &&
                   ((phase_ff == PHASE_EMIT_A) || (phase_ff == PHASE_EMIT_B));
      tri_out    = '0;
      tri_out.ax[SLOT_WIDTH-1:0] = a_x_ff;
      tri_out.ay[SLOT_WIDTH-1:0] = a_y_ff;
      tri_out.bx[SLOT_WIDTH-1:0] = b_x_ff;
      tri_out.by[SLOT_WIDTH-1:0] = b_y_ff;
      tri_out.cx[SLOT_WIDTH-1:0] = cur_x;
      tri_out.cy[SLOT_WIDTH-1:0] = cur_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IGNORED;
         phase_ff <= PHASE_FIRST;
         a_x_ff   <= '0;
         a_y_ff   <= '0;
         b_x_ff   <= '0;
         b_y_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         a_x_ff   <= a_x_in;
         a_y_ff   <= a_y_in;
         b_x_ff   <= b_x_in;
         b_y_ff   <= b_y_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tpa_rsp_queue.sv @@
`default_nettype none
module tpa_rsp_queue
   import tpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire tri_type push_tri,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output tri_type      head_tri
);

   tri_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_tri  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_tri;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/triangle_primitive_assembler_top.sv @@
// a triangle is held in the result queue from the cycle after the vertex transaction that closes it
// throughput: one request transaction per cycle while req_tready is high, set by the corner update
// req_tready falls only while both entries of the two-deep result queue are occupied
// reset (synchronous, active high) selects the ignored mode, clears the phase and the corners
// and empties the result queue
`default_nettype none
module triangle_primitive_assembler_top
   import tpa_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // prim_type, vert_x, vert_y, zero pad
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // action
   input  wire logic                       req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata
);

   logic    accept, emit_valid, full, not_empty, pop;
   tri_type tri_new, tri_head;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !full;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = not_empty;

   tpa_assemble #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_assemble (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_tuser),
      .prim_type  (req_tdata[1:0]),
      .vert_x     (req_tdata[2+:FIELD_WIDTH]),
      .vert_y     (req_tdata[2+FIELD_WIDTH+:FIELD_WIDTH]),
      .emit_valid (emit_valid),
      .tri_out    (tri_new)
   );

   tpa_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit_valid),
      .push_tri  (tri_new),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_tri  (tri_head)
   );

   assign rsp_tdata = {tri_head.cy, tri_head.cx, tri_head.by,
                       tri_head.bx, tri_head.ay, tri_head.ax};

endmodule
`default_nettype wire

@@ rtl/core/tpa_checker.sv @@
`default_nettype none
module tpa_checker
   import tpa_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // a result waiting for the sink does not vanish
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a fresh result only ever follows a vertex transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == ACT_VERTEX)))
      else $error("result without a vertex transaction");

endmodule

bind triangle_primitive_assembler_top tpa_checker u_tpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ verif/tb_triangle_primitive_assembler_top.sv @@
`default_nettype none
module tb_triangle_primitive_assembler_top;
   import tpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 32;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int RANDOM_ITEMS = 400;

   // field-by-field name list for mismatch reports, lowest tdata field first
   localparam string CORNER_NAME [6] = '{"tri_ax", "tri_ay", "tri_bx", "tri_by",
                                         "tri_cx", "tri_cy"};

   // mirrors the assembler: holds the current mode, phase and two stored corners,
   // and queues the triangles that the accepted vertex transactions should produce
   class tri_scoreboard;
      mode_type                    mode;
      phase_type                   phase;
      logic [CW-1:0]               ax, ay, bx, by;
      logic [RSP_TDATA_WIDTH-1:0]  pending_tris[$];
      int                          n_begins, n_vertices, n_ignored;
      int                          n_tris, n_checked, n_mismatches;
      int                          tris_per_mode[3];

      function new();
         mode  = MODE_IGNORED;
         phase = PHASE_FIRST;
         ax = '0;
         ay = '0;
         bx = '0;
         by = '0;
      endfunction

      // returns 1 when the transaction had any effect on the assembler
      function bit note_transaction(logic act, logic [1:0] prim, logic [CW-1:0] x,
                                    logic [CW-1:0] y);
         logic [RSP_TDATA_WIDTH-1:0] tri_bits;
         if (act == ACT_BEGIN) begin
            mode  = mode_type'(prim);
            phase = PHASE_FIRST;
            n_begins++;
            return 1'b1;
         end
         if (mode == MODE_IGNORED) begin
            n_ignored++;
            return 1'b0;
         end
         n_vertices++;
         case (phase)
            PHASE_FIRST: begin
               ax = x;
               ay = y;
               phase = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               bx = x;
               by = y;
               phase = PHASE_EMIT_A;
            end
            default: begin
               tri_bits = {y, x, by, bx, ay, ax};
               pending_tris.push_back(tri_bits);
               n_tris++;
               tris_per_mode[mode]++;
               if (mode == MODE_LIST) begin
                  phase = PHASE_FIRST;
               end else if (mode == MODE_FAN) begin
                  bx = x;
                  by = y;
               end else if (phase == PHASE_EMIT_A) begin
                  // strip alternates which stored corner the new vertex replaces
                  ax = x;
                  ay = y;
                  phase = PHASE_EMIT_B;
               end else begin
                  bx = x;
                  by = y;
                  phase = PHASE_EMIT_A;
               end
            end
         endcase
         return 1'b1;
      endfunction

      function void check_triangle(logic [RSP_TDATA_WIDTH-1:0] got);
         logic [RSP_TDATA_WIDTH-1:0] want;
         n_checked++;
         if (pending_tris.size() == 0) begin
            if (n_mismatches < MAX_REPORTS)
               $display("[%0t] unexpected triangle on rsp: %h", $realtime, got);
            n_mismatches++;
            return;
         end
         want = pending_tris.pop_front();
         for (int i = 0; i < 6; i++) begin
            if (got[i*CW +: CW] !== want[i*CW +: CW]) begin
               if (n_mismatches < MAX_REPORTS)
                  $display("[%0t] triangle %0d %s: expected %h, got %h", $realtime,
                           n_checked, CORNER_NAME[i], want[i*CW +: CW], got[i*CW +: CW]);
               n_mismatches++;
            end
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // prim_type, vert_x, vert_y, zero pad
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   // action
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   tri_scoreboard sb = new();
   bit            calm_window = 1'b0;
   bit            hold_off_request = 1'b0;
   bit            hold_off_done = 1'b0;
   int            n_accepted = 0;
   int            n_stalled_cycles = 0;

   triangle_primitive_assembler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic act, input logic [1:0] prim,
                            input logic [CW-1:0] x, input logic [CW-1:0] y,
                            output bit counted);
      while (!calm_window && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_TDATA_WIDTH - 2 - 2*CW){1'b0}}, y, x, prim};
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
         n_stalled_cycles++;
      end
      counted = sb.note_transaction(act, prim, x, y);
      n_accepted++;
      @(negedge clock);
   endtask

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(CW-1){1'b0}}};
         1:       return {1'b0, {(CW-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      // the ignored mode is kept rare so that most runs assemble triangles
      return ($urandom_range(0, 99) < 15) ? MODE_IGNORED : 2'($urandom_range(0, 2));
   endfunction

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_tready <= calm_window || ($urandom_range(0, 99) >= 23);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_triangle(rsp_tdata);
   end

   initial begin
      #200us;
      $display("timeout: %0d triangles still outstanding", sb.pending_tris.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      bit              counted;
      int              n_random;
      int              run_len;
      logic [1:0]      mode_pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // vertex ahead of any begin is dropped
      send_item(ACT_VERTEX, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, counted);
      // list, coordinates on begin must be ignored
      send_item(ACT_BEGIN, MODE_LIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, counted);
      send_item(ACT_VERTEX, 2'd3, 32'h8000_0000, 32'h7FFF_FFFF, counted);
      send_item(ACT_VERTEX, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000, counted);
      send_item(ACT_VERTEX, 2'd2, 32'h0000_0000, 32'hFFFF_FFFF, counted);
      // fan: first corner stays put
      send_item(ACT_BEGIN, MODE_FAN, 32'h0, 32'h0, counted);
      send_item(ACT_VERTEX, 2'd3, 32'h0001_0000, 32'hFFFF_0000, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0002_8000, 32'h0000_8000, counted);
      send_item(ACT_VERTEX, 2'd2, 32'hFFFF_FFFF, 32'h0000_0001, counted);
      send_item(ACT_VERTEX, 2'd1, 32'h8000_0001, 32'h7FFF_FFFE, counted);
      // strip: alternating corner replacement
      send_item(ACT_BEGIN, MODE_STRIP, 32'h1234_5678, 32'h9ABC_DEF0, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0000_0001, 32'h0000_0002, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0000_0003, 32'h0000_0004, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0000_0005, 32'h0000_0006, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0000_0007, 32'h0000_0008, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0000_0009, 32'h0000_000A, counted);
      // ignored mode swallows vertices
      send_item(ACT_BEGIN, MODE_IGNORED, 32'h0, 32'h0, counted);
      send_item(ACT_VERTEX, 2'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D, counted);
      send_item(ACT_VERTEX, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA, counted);
      // a begin mid-triangle drops the partial one
      send_item(ACT_BEGIN, MODE_LIST, 32'h0, 32'h0, counted);
      send_item(ACT_VERTEX, 2'd0, 32'hAAAA_AAAA, 32'h5555_5555, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h5555_5555, 32'hAAAA_AAAA, counted);
      send_item(ACT_BEGIN, MODE_FAN, 32'h0, 32'h0, counted);
      send_item(ACT_VERTEX, 2'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, counted);

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         calm_window = (n_random >= 180 && n_random < 260);
         if (n_random >= 80)
            hold_off_request = 1'b1;
         if ($urandom_range(0, 99) < 85) begin
            mode_pick = pick_mode();
            send_item(ACT_BEGIN, mode_pick, $urandom(), $urandom(), counted);
            n_random += counted;
            run_len = $urandom_range(0, 12);
            for (int i = 0; i < run_len; i++) begin
               send_item(ACT_VERTEX, 2'($urandom()), pick_coord(), pick_coord(), counted);
               n_random += counted;
            end
         end else begin
            send_item(1'($urandom()), 2'($urandom()), pick_coord(), pick_coord(), counted);
            n_random += counted;
         end
      end
      calm_window = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_tris.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d transactions in (%0d begins, %0d vertices, %0d dropped), %0d input stall cycles",
               n_accepted, sb.n_begins, sb.n_vertices, sb.n_ignored, n_stalled_cycles);
      $display("%0d triangles checked: list %0d, fan %0d, strip %0d, %0d mismatches",
               sb.n_checked, sb.tris_per_mode[MODE_LIST], sb.tris_per_mode[MODE_FAN],
               sb.tris_per_mode[MODE_STRIP], sb.n_mismatches);
      if (sb.n_mismatches == 0 && sb.pending_tris.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
